[design/irqmd_pkg.sv]
// Shared types and constants for the interrupt mask and dispatch manager.
// Used by every module of the block; depends on nothing.
`default_nettype none

package irqmd_pkg;

  localparam int NUM_LINES      = 16;
  localparam int LINE_W         = $clog2(NUM_LINES);
  localparam int DEPTH_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int MAX_RESULTS    = 3;
  localparam int CNT_W          = 2;

  // Fixed controller command bytes.
  localparam logic [7:0] OCW2_NONSPEC_EOI = 8'h20;
  localparam logic [7:0] OCW2_CASCADE_EOI = 8'h62;  // specific EOI, line 2

  typedef enum logic [2:0] {
    CMD_RAISE   = 3'd0,
    CMD_DONE    = 3'd1,
    CMD_DISABLE = 3'd2,
    CMD_ENABLE  = 3'd3,
    CMD_INSTALL = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_MCMD  = 2'd0,  // 0x20
    SEL_MMASK = 2'd1,  // 0x21
    SEL_SCMD  = 2'd2,  // 0xA0
    SEL_SMASK = 2'd3   // 0xA1
  } sel_e;

  typedef struct packed {
    logic       has_write;
    sel_e       sel;
    logic [7:0] data;
  } wr_t;

  // One classified command: its port writes and dispatch decision.
  typedef struct packed {
    logic [CNT_W-1:0]       count;  // number of results, 1..3
    wr_t [MAX_RESULTS-1:0]  wr;
    logic                   dispatch;
    logic [LINE_W-1:0]      line;
  } job_t;

  typedef struct packed {
    logic              strobe;
    logic              has_write;
    logic [1:0]        port_select;
    logic [7:0]        port_data;
    logic              dispatch;
    logic [LINE_W-1:0] dispatch_line;
    logic              last_result;
  } result_t;

endpackage

`default_nettype wire

[design/irqmd_front.sv]
// Front end: decodes commands, updates mask/mark/depth state, builds a job.
// Depends on irqmd_pkg.
`default_nettype none

module irqmd_front #(
  parameter int DepthBits = irqmd_pkg::DEPTH_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [2:0]                   command_i,
  input  wire logic [irqmd_pkg::LINE_W-1:0] irq_line_i,
  output irqmd_pkg::job_t                   job_o
);

  localparam int NL = irqmd_pkg::NUM_LINES;
  localparam logic [DepthBits-1:0] DepthMax = '1;

  logic [NL-1:0] mask_q, mask_d;
  logic [NL-1:0] dis_q, dis_d;
  logic [NL-1:0] busy_q, busy_d;
  logic [NL-1:0] inst_q, inst_d;
  logic [DepthBits-1:0] depth_q [NL];
  logic [DepthBits-1:0] depth_cur, depth_nxt;
  logic                 depth_we;

  logic [NL-1:0]    bit_sel;
  logic             slave;
  logic             wr_mask;
  logic             is_raise;
  logic             can_run;
  irqmd_pkg::wr_t   mask_wr;
  irqmd_pkg::job_t  job;

  assign bit_sel   = NL'(1) << irq_line_i;
  assign slave     = irq_line_i[irqmd_pkg::LINE_W-1];
  assign depth_cur = depth_q[irq_line_i];
  assign can_run   = |(bit_sel & inst_q & ~dis_q & ~busy_q);

  always_comb begin
    mask_d    = mask_q;
    dis_d     = dis_q;
    busy_d    = busy_q;
    inst_d    = inst_q;
    depth_nxt = depth_cur;
    depth_we  = 1'b0;
    wr_mask   = 1'b0;
    is_raise  = 1'b0;
    unique case (irqmd_pkg::cmd_e'(command_i))
      irqmd_pkg::CMD_RAISE: begin
        is_raise = 1'b1;
        mask_d   = mask_q | bit_sel;
        if (can_run) begin
          busy_d = busy_q | bit_sel;
        end
      end
      irqmd_pkg::CMD_DONE: begin
        busy_d = busy_q & ~bit_sel;
        if (!(|(dis_q & bit_sel))) begin
          mask_d  = mask_q & ~bit_sel;
          wr_mask = 1'b1;
        end
      end
      irqmd_pkg::CMD_DISABLE: begin
        if (depth_cur == '0) begin
          dis_d   = dis_q | bit_sel;
          mask_d  = mask_q | bit_sel;
          wr_mask = 1'b1;
        end
        if (depth_cur != DepthMax) begin
          depth_nxt = depth_cur + DepthBits'(1);
          depth_we  = 1'b1;
        end
      end
      irqmd_pkg::CMD_ENABLE: begin
        if (depth_cur == DepthBits'(1)) begin
          dis_d   = dis_q & ~bit_sel;
          mask_d  = mask_q & ~bit_sel;
          wr_mask = 1'b1;
        end
        if (depth_cur != '0) begin
          depth_nxt = depth_cur - DepthBits'(1);
          depth_we  = 1'b1;
        end
      end
      irqmd_pkg::CMD_INSTALL: begin
        inst_d    = inst_q | bit_sel;
        depth_nxt = '0;
        depth_we  = 1'b1;
        dis_d     = dis_q & ~bit_sel;
        mask_d    = mask_q & ~bit_sel;
        wr_mask   = 1'b1;
      end
      default: begin
      end
    endcase

    // Mask byte of the owning controller, taken from the updated image.
    mask_wr.has_write = 1'b1;
    mask_wr.sel       = slave ? irqmd_pkg::SEL_SMASK : irqmd_pkg::SEL_MMASK;
    mask_wr.data      = slave ? mask_d[15:8] : mask_d[7:0];

    job          = '0;
    job.dispatch = is_raise & can_run;
    job.line     = (is_raise & can_run) ? irq_line_i : '0;
    if (is_raise) begin
      job.wr[0] = mask_wr;
      if (slave) begin
        job.count = irqmd_pkg::CNT_W'(3);
        job.wr[1] = '{1'b1, irqmd_pkg::SEL_MCMD, irqmd_pkg::OCW2_CASCADE_EOI};
        job.wr[2] = '{1'b1, irqmd_pkg::SEL_SCMD, irqmd_pkg::OCW2_NONSPEC_EOI};
      end else begin
        job.count = irqmd_pkg::CNT_W'(2);
        job.wr[1] = '{1'b1, irqmd_pkg::SEL_MCMD, irqmd_pkg::OCW2_NONSPEC_EOI};
      end
    end else begin
      job.count = irqmd_pkg::CNT_W'(1);
      if (wr_mask) begin
        job.wr[0] = mask_wr;
      end
    end
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
      dis_q  <= '1;
      busy_q <= '0;
      inst_q <= '0;
      for (int i = 0; i < NL; i++) begin
        depth_q[i] <= '0;
      end
    end else if (accept_i) begin
      mask_q <= mask_d;
      dis_q  <= dis_d;
      busy_q <= busy_d;
      inst_q <= inst_d;
      if (depth_we) begin
        depth_q[irq_line_i] <= depth_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[design/irqmd_queue.sv]
// Small job FIFO between the front end and the write sequencer.
// Depends on irqmd_pkg.
`default_nettype none

module irqmd_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire irqmd_pkg::job_t job_i,
  input  wire logic      pop_i,
  output irqmd_pkg::job_t job_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int Depth = irqmd_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  irqmd_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/irqmd_back.sv]
// Back end: plays out the port writes of the head job, one per cycle.
// Depends on irqmd_pkg.
`default_nettype none

module irqmd_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire irqmd_pkg::job_t job_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output irqmd_pkg::result_t res_o
);

  localparam int CW = irqmd_pkg::CNT_W;

  logic [CW-1:0]      idx_q, idx_d;
  logic               last;
  irqmd_pkg::wr_t     cur;
  irqmd_pkg::result_t res_q, res_d;

  always_comb begin
    case (idx_q)
      CW'(0):  cur = job_i.wr[0];
      CW'(1):  cur = job_i.wr[1];
      default: cur = job_i.wr[2];
    endcase
    last  = (idx_q == CW'(job_i.count - CW'(1)));
    pop_o = !empty_i && last;
    idx_d = idx_q;
    if (!empty_i) begin
      idx_d = last ? '0 : idx_q + CW'(1);
    end

    res_d               = '0;
    res_d.strobe        = !empty_i;
    if (!empty_i) begin
      res_d.has_write     = cur.has_write;
      res_d.port_select   = cur.sel;
      res_d.port_data     = cur.data;
      res_d.dispatch      = job_i.dispatch & last;
      res_d.dispatch_line = last ? job_i.line : '0;
      res_d.last_result   = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      res_q <= '0;
    end else begin
      idx_q <= idx_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[design/irq_mask_and_dispatch_manager.sv]
// Interrupt mask and dispatch manager, top level.
// Depends on irqmd_pkg, irqmd_front, irqmd_queue and irqmd_back.
//
// Tracks 16 interrupt lines behind a cascaded master/slave pair of 8259A
// style controllers and turns each command into one to three results, each
// a controller port write or an empty result. A command transaction is
// taken at a rising edge with start high and busy low. The front end
// applies the command to the mask image, the disabled/in-progress/installed
// marks and the per-line nesting depth in that same cycle, so state is
// always current for the next command. The resulting write list goes into
// a two-entry job queue; the back end then puts one result per cycle on
// the result ports with strobe_o high for exactly one cycle. There is no
// backpressure on results: the receiver must take every strobed result.
// With the queue empty, the first result of a command passes through the
// job queue and the back end's output register before it reaches the
// ports. A raise costs two results (master line) or three (slave line);
// every other command costs one, so the back end's one-write-per-cycle
// sequencer sets the sustained command rate. busy rises when the queue
// holds two jobs and falls as soon as the back end retires one.
// After reset every line is masked and disabled, nothing is installed or
// in progress, and all nesting depths are zero.
`default_nettype none

module irq_mask_and_dispatch_manager #(
  parameter int DepthBits = irqmd_pkg::DEPTH_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   command_i,
  input  wire logic [irqmd_pkg::LINE_W-1:0] irq_line_i,
  output logic                              strobe_o,
  output logic                              has_write_o,
  output logic [1:0]                        port_select_o,
  output logic [7:0]                        port_data_o,
  output logic                              dispatch_o,
  output logic [irqmd_pkg::LINE_W-1:0]      dispatch_line_o,
  output logic                              last_result_o
);

  logic               accept;
  logic               q_empty, q_full, q_pop;
  irqmd_pkg::job_t    job_in, job_head;
  irqmd_pkg::result_t res;

  // Command transaction handshake.
  assign busy   = q_full;
  assign accept = start && !q_full;

  irqmd_front #(
    .DepthBits(DepthBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .command_i (command_i),
    .irq_line_i(irq_line_i),
    .job_o     (job_in)
  );

  irqmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .job_i  (job_in),
    .pop_i  (q_pop),
    .job_o  (job_head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  irqmd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_head),
    .empty_i(q_empty),
    .pop_o  (q_pop),
    .res_o  (res)
  );

  // Result transaction ports, straight from the back end's output register.
  assign strobe_o        = res.strobe;
  assign has_write_o     = res.has_write;
  assign port_select_o   = res.port_select;
  assign port_data_o     = res.port_data;
  assign dispatch_o      = res.dispatch;
  assign dispatch_line_o = res.dispatch_line;
  assign last_result_o   = res.last_result;

endmodule

`default_nettype wire

[design/irqmd_checker.sv]
// Port-level checker for the interrupt mask and dispatch manager, and its bind.
// Depends on irqmd_pkg and the top-level port list.
`default_nettype none

module irqmd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [2:0]                   command_i,
  input wire logic [irqmd_pkg::LINE_W-1:0] irq_line_i,
  input wire logic                         strobe_o,
  input wire logic                         has_write_o,
  input wire logic [1:0]                   port_select_o,
  input wire logic [7:0]                   port_data_o,
  input wire logic                         dispatch_o,
  input wire logic [irqmd_pkg::LINE_W-1:0] dispatch_line_o,
  input wire logic                         last_result_o
);

  // An accepted command is always followed by a strobed result on the ports.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 strobe_o)
    else $error("no result two cycles after an accepted command");

  // Dispatch only on the final result of a command.
  a_dispatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dispatch_o |-> (strobe_o && last_result_o && has_write_o))
    else $error("dispatch outside the final result");

  a_line_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !dispatch_o) |-> (dispatch_line_o == '0))
    else $error("dispatch_line set without dispatch");

  // A result without a write is a lone, empty result.
  a_nowrite_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !has_write_o) |->
      (last_result_o && port_data_o == 8'h00 && port_select_o == 2'd0))
    else $error("malformed empty result");

  // Command ports only ever see the EOI bytes.
  a_cmd_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && has_write_o && (port_select_o == irqmd_pkg::SEL_MCMD ||
                                 port_select_o == irqmd_pkg::SEL_SCMD)) |->
      (port_data_o == irqmd_pkg::OCW2_NONSPEC_EOI ||
       port_data_o == irqmd_pkg::OCW2_CASCADE_EOI))
    else $error("unexpected byte on a command port");

endmodule

bind irq_mask_and_dispatch_manager irqmd_checker u_irqmd_checker (.*);

`default_nettype wire

[bench/irq_mask_and_dispatch_manager_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for irq_mask_and_dispatch_manager: commands in, port writes out.
// Depends on irqmd_pkg and the block's RTL only.

module irq_mask_and_dispatch_manager_tb;

  localparam int NUM_LINES   = irqmd_pkg::NUM_LINES;
  localparam int LINE_W      = irqmd_pkg::LINE_W;
  localparam int MAX_RESULTS = irqmd_pkg::MAX_RESULTS;
  localparam int DEPTH_BITS  = irqmd_pkg::DEPTH_BITS_DEF;
  localparam int DEPTH_TOP   = (1 << DEPTH_BITS) - 1;   // nesting depth saturates here
  localparam int RAND_CMDS   = 220;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 10;                    // quiet time after the last result
  localparam int MAX_PRINTS  = 40;

  // Command codes the block ignores (one empty result each).
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // One command waiting to be sent; gap_after is idle cycles after it is
  // taken, drain holds it back until every expected write has arrived.
  typedef struct {
    logic [2:0]        cmd;
    logic [LINE_W-1:0] line;
    int                gap_after;
    bit                drain;
  } pic_cmd_t;

  // One port write (or empty result) as seen on the result ports.
  typedef struct packed {
    logic              has_write;
    logic [1:0]        sel;
    logic [7:0]        data;
    logic              dispatch;
    logic [LINE_W-1:0] dline;
    logic              last;
  } port_wr_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [2:0]          command_i = '0;
  logic [LINE_W-1:0]   irq_line_i = '0;
  logic                strobe_o;
  logic                has_write_o;
  logic [1:0]          port_select_o;
  logic [7:0]          port_data_o;
  logic                dispatch_o;
  logic [LINE_W-1:0]   dispatch_line_o;
  logic                last_result_o;

  irq_mask_and_dispatch_manager #(
    .DepthBits(DEPTH_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .irq_line_i     (irq_line_i),
    .strobe_o       (strobe_o),
    .has_write_o    (has_write_o),
    .port_select_o  (port_select_o),
    .port_data_o    (port_data_o),
    .dispatch_o     (dispatch_o),
    .dispatch_line_o(dispatch_line_o),
    .last_result_o  (last_result_o)
  );

  // Shadow copy of the controller state, updated when a command is taken.
  logic [NUM_LINES-1:0]  pic_mask;
  logic [NUM_LINES-1:0]  disabled_lines;
  logic [NUM_LINES-1:0]  in_service;
  logic [NUM_LINES-1:0]  installed_lines;
  logic [DEPTH_BITS-1:0] nest_level [NUM_LINES];

  pic_cmd_t pending_cmds [$];
  port_wr_t expected_writes [$];

  int  cmds_queued   = 0;
  int  cmds_taken    = 0;
  int  writes_seen   = 0;
  int  dispatch_seen = 0;
  int  results_seen  = 0;
  int  errors        = 0;
  int  cycle_count   = 0;
  int  gap_left      = 0;
  bit  no_idle       = 0;
  pic_cmd_t next_cmd;

  // Clock: 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Mask byte write for the controller that owns the line, from the
  // current mask image.
  function automatic port_wr_t mask_write(input logic [LINE_W-1:0] ln);
    port_wr_t w;
    w = '0;
    w.has_write = 1'b1;
    if (ln[3]) begin
      w.sel  = irqmd_pkg::SEL_SMASK;
      w.data = pic_mask[15:8];
    end else begin
      w.sel  = irqmd_pkg::SEL_MMASK;
      w.data = pic_mask[7:0];
    end
    return w;
  endfunction

  // Apply one taken command to the shadow state and queue the writes it
  // must produce, in order.
  task automatic predict_writes(input logic [2:0] c, input logic [LINE_W-1:0] ln);
    port_wr_t             wr [MAX_RESULTS];
    port_wr_t             w;
    int                   n;
    logic [NUM_LINES-1:0] bitm;
    n = 0;
    bitm = '0;
    bitm[ln] = 1'b1;
    case (c)
      irqmd_pkg::CMD_RAISE: begin
        pic_mask |= bitm;
        wr[n] = mask_write(ln);
        n++;
        w = '0;
        w.has_write = 1'b1;
        if (ln[3]) begin
          // slave line: specific EOI for the cascade input first
          w.sel  = irqmd_pkg::SEL_MCMD;
          w.data = irqmd_pkg::OCW2_CASCADE_EOI;
          wr[n] = w;
          n++;
          w.sel  = irqmd_pkg::SEL_SCMD;
          w.data = irqmd_pkg::OCW2_NONSPEC_EOI;
          wr[n] = w;
          n++;
        end else begin
          w.sel  = irqmd_pkg::SEL_MCMD;
          w.data = irqmd_pkg::OCW2_NONSPEC_EOI;
          wr[n] = w;
          n++;
        end
        if ((installed_lines & bitm) != 0 && (disabled_lines & bitm) == 0 &&
            (in_service & bitm) == 0) begin
          in_service |= bitm;
          wr[n-1].dispatch = 1'b1;
          wr[n-1].dline    = ln;
        end
      end
      irqmd_pkg::CMD_DONE: begin
        in_service &= ~bitm;
        if ((disabled_lines & bitm) == 0) begin
          pic_mask &= ~bitm;
          wr[n] = mask_write(ln);
          n++;
        end
      end
      irqmd_pkg::CMD_DISABLE: begin
        if (nest_level[ln] == 0) begin
          disabled_lines |= bitm;
          pic_mask |= bitm;
          wr[n] = mask_write(ln);
          n++;
        end
        if (nest_level[ln] != DEPTH_BITS'(DEPTH_TOP))
          nest_level[ln] = nest_level[ln] + 1'b1;
      end
      irqmd_pkg::CMD_ENABLE: begin
        if (nest_level[ln] == 1) begin
          disabled_lines &= ~bitm;
          pic_mask &= ~bitm;
          wr[n] = mask_write(ln);
          n++;
        end
        if (nest_level[ln] != 0)
          nest_level[ln] = nest_level[ln] - 1'b1;
      end
      irqmd_pkg::CMD_INSTALL: begin
        installed_lines |= bitm;
        nest_level[ln] = '0;
        disabled_lines &= ~bitm;
        pic_mask &= ~bitm;
        wr[n] = mask_write(ln);
        n++;
      end
      default: ;  // reserved codes leave the state alone
    endcase
    if (n == 0) begin
      wr[0] = '0;  // nothing to write: one empty result
      n = 1;
    end
    wr[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      expected_writes.push_back(wr[i]);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Sender idle time: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_cmd(input logic [2:0] c, input logic [LINE_W-1:0] ln,
                           input bit drain = 1'b0);
    pic_cmd_t p;
    p.cmd       = c;
    p.line      = ln;
    p.gap_after = pick_gap();
    p.drain     = drain;
    pending_cmds.push_back(p);
    cmds_queued++;
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued commands, one transaction per accepted start.
  // The predictor runs at the edge that takes the transaction, so the
  // shadow state advances in the same order as the block's own state.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      command_i  <= '0;
      irq_line_i <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        predict_writes(command_i, irq_line_i);
        cmds_taken++;
      end
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].drain && expected_writes.size() != 0)) begin
        start <= 1'b0;
      end else begin
        next_cmd   = pending_cmds.pop_front();
        gap_left   = next_cmd.gap_after;
        start      <= 1'b1;
        command_i  <= next_cmd.cmd;
        irq_line_i <= next_cmd.line;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobed result is matched against the oldest
  // expectation, field by field. No backpressure exists on this side.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    port_wr_t exp_wr;
    if (rst_ni && strobe_o) begin
      results_seen++;
      if (has_write_o)
        writes_seen++;
      if (dispatch_o)
        dispatch_seen++;
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected result sel %0d data %02h",
                                  port_select_o, port_data_o));
      end else begin
        exp_wr = expected_writes.pop_front();
        if (has_write_o !== exp_wr.has_write)
          report_mismatch($sformatf("result %0d: has_write %b, want %b",
                                    results_seen, has_write_o, exp_wr.has_write));
        if (port_select_o !== exp_wr.sel)
          report_mismatch($sformatf("result %0d: port_select %0d, want %0d",
                                    results_seen, port_select_o, exp_wr.sel));
        if (port_data_o !== exp_wr.data)
          report_mismatch($sformatf("result %0d: port_data %02h, want %02h",
                                    results_seen, port_data_o, exp_wr.data));
        if (dispatch_o !== exp_wr.dispatch)
          report_mismatch($sformatf("result %0d: dispatch %b, want %b",
                                    results_seen, dispatch_o, exp_wr.dispatch));
        if (dispatch_line_o !== exp_wr.dline)
          report_mismatch($sformatf("result %0d: dispatch_line %0d, want %0d",
                                    results_seen, dispatch_line_o, exp_wr.dline));
        if (last_result_o !== exp_wr.last)
          report_mismatch($sformatf("result %0d: last_result %b, want %b",
                                    results_seen, last_result_o, exp_wr.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d of %0d commands taken",
               cycle_count, cmds_taken, cmds_queued);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    logic [LINE_W-1:0] ln;
    int                kind;
    int                k;
    int                j;

    // Reset image of the shadow state.
    pic_mask        = '1;
    disabled_lines  = '1;
    in_service      = '0;
    installed_lines = '0;
    for (int i = 0; i < NUM_LINES; i++)
      nest_level[i] = '0;

    // Directed: reset-state corner cases first, then dispatch and nesting.
    queue_cmd(irqmd_pkg::CMD_RAISE, 4'd0);     // masked, disabled, not installed
    queue_cmd(irqmd_pkg::CMD_DONE, 4'd9);      // done on a disabled idle line
    queue_cmd(irqmd_pkg::CMD_ENABLE, 4'd5);    // enable at depth zero: no write
    queue_cmd(CMD_RSVD7, 4'd15);               // reserved codes: empty result
    queue_cmd(CMD_RSVD5, 4'd10);
    queue_cmd(irqmd_pkg::CMD_INSTALL, 4'd0);
    queue_cmd(irqmd_pkg::CMD_INSTALL, 4'd15);
    queue_cmd(irqmd_pkg::CMD_INSTALL, 4'd8);
    queue_cmd(irqmd_pkg::CMD_INSTALL, 4'd7);
    queue_cmd(irqmd_pkg::CMD_RAISE, 4'd0, 1'b1);  // master dispatch, after a full drain
    queue_cmd(irqmd_pkg::CMD_RAISE, 4'd0);     // still in service: no dispatch
    queue_cmd(irqmd_pkg::CMD_DONE, 4'd0);
    queue_cmd(irqmd_pkg::CMD_RAISE, 4'd15);    // slave dispatch, three writes
    queue_cmd(irqmd_pkg::CMD_RAISE, 4'd15);
    queue_cmd(irqmd_pkg::CMD_DONE, 4'd15);
    queue_cmd(irqmd_pkg::CMD_DISABLE, 4'd15);  // depth 0 -> 1 writes the mask
    queue_cmd(irqmd_pkg::CMD_DISABLE, 4'd15);  // nested: no write
    queue_cmd(irqmd_pkg::CMD_DONE, 4'd15);     // disabled: stays masked
    queue_cmd(irqmd_pkg::CMD_ENABLE, 4'd15);
    queue_cmd(irqmd_pkg::CMD_ENABLE, 4'd15);   // back to depth 0: unmask
    queue_cmd(irqmd_pkg::CMD_DISABLE, 4'd3);
    queue_cmd(irqmd_pkg::CMD_ENABLE, 4'd3);    // enabled, not installed
    queue_cmd(irqmd_pkg::CMD_RAISE, 4'd3);     // no dispatch, not marked busy
    queue_cmd(irqmd_pkg::CMD_DONE, 4'd7);      // done on an idle installed line
    queue_cmd(CMD_RSVD6, 4'd11);

    // Saturate one line's nesting depth; it stays near the top until an install
    // on that line clears it, so random nesting there keeps hitting the saturation point.
    no_idle = 1'b1;
    repeat (DEPTH_TOP + 2) queue_cmd(irqmd_pkg::CMD_DISABLE, 4'd12);
    no_idle = 1'b0;

    // Random part: mostly raise/done episodes and balanced nesting on
    // random lines, with some stray commands and full drains.
    k = cmds_queued;
    while (cmds_queued < k + RAND_CMDS) begin
      ln      = LINE_W'($urandom_range(0, NUM_LINES - 1));
      no_idle = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 9);
      if (kind <= 5) begin
        if ($urandom_range(0, 3) == 0)
          queue_cmd(irqmd_pkg::CMD_INSTALL, ln);
        queue_cmd(irqmd_pkg::CMD_RAISE, ln);
        if ($urandom_range(0, 2) == 0)
          queue_cmd(irqmd_pkg::CMD_RAISE, ln);   // re-raise while in service
        if ($urandom_range(0, 4) != 0)
          queue_cmd(irqmd_pkg::CMD_DONE, ln);
      end else if (kind <= 7) begin
        j = $urandom_range(1, 3);
        repeat (j) queue_cmd(irqmd_pkg::CMD_DISABLE, ln);
        if ($urandom_range(0, 1) == 1)
          queue_cmd(irqmd_pkg::CMD_RAISE, ln);
        j = j + $urandom_range(0, 2) - 1;    // sometimes one short or one extra
        repeat (j) queue_cmd(irqmd_pkg::CMD_ENABLE, ln);
      end else if (kind == 8) begin
        queue_cmd(3'($urandom_range(0, 7)), LINE_W'($urandom_range(0, NUM_LINES - 1)));
      end else begin
        queue_cmd(irqmd_pkg::CMD_RAISE, ln, 1'b1);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_taken != cmds_queued || expected_writes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands: %0d results, %0d port writes, %0d dispatches",
             cmds_taken, results_seen, writes_seen, dispatch_seen);
    $display("Covered reserved codes, depth saturation at %0d and idle/busy corners",
             DEPTH_TOP);
    if (errors == 0 && expected_writes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_writes.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
